FILE: rtl/lap3_pkg.sv
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared widths, register codes and reset values of the 3x3 Laplacian filter.
// ----------------------------------------------------------------------------
package lap3_pkg;

    localparam int PIX_W          = 8;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int MAX_WIDTH_DEF  = 1024;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd332;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd271;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

endpackage

FILE: rtl/lap3_if.sv
// ----------------------------------------------------------------------------
// lap3 stream interfaces
// Valid/ready channels for input pixels and filtered results.
// ----------------------------------------------------------------------------
interface lap3_pix_if;
    import lap3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lap3_res_if;
    import lap3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] filtered;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output filtered, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input filtered, input row_end, input frame_end,
                    output ready);
endinterface

FILE: rtl/laplacian_3x3_filter.sv
// A result is valid in the cycle after the transfer of the pixel below and right of its centre.
// Throughput: one pixel per cycle while ready; line buffer reads fetch the next column ahead.
// Input ready drops only while a result is held and the output is stalled.
// Reset clears counters, window and output valid, and loads width 332 and height 271.
// Line buffers are not cleared; a write to the width or height register restarts the frame.
// ----------------------------------------------------------------------------
// laplacian_3x3_filter
// Streaming 4-neighbour Laplacian over raster-order 8-bit frames; emits the
// clamped response of each interior pixel with row and frame end flags.
// ----------------------------------------------------------------------------
module laplacian_3x3_filter #(
    parameter int MAX_WIDTH = lap3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lap3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lap3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lap3_pix_if.sink                         i_pix,
    lap3_res_if.source                       o_res
);
    import lap3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CW-1:0]       r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;

    logic [PIX_W-1:0] line_above     [MAX_WIDTH];
    logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_top, r_rd_mid;

    logic [PIX_W-1:0] r_c1_top, r_c1_mid, r_c1_bot, r_c2_mid;

    logic             r_ovalid;
    logic [PIX_W-1:0] r_filtered;
    logic             r_row_end;
    logic             r_frame_end;

    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                last_col, last_row, interior, accept, cfg_hit;
    logic signed [10:0]  sum;
    logic [PIX_W-1:0]    clamped;

    assign i_pix.ready = !r_ovalid || o_res.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        eff_w = EW'(r_width);
        if (eff_w < EW'(3)) begin
            eff_w = EW'(3);
        end else if (eff_w > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end
        eff_h = (r_height < HEIGHT_MIN) ? HEIGHT_MIN : r_height;
    end

    assign last_col = (EW'(r_col) + EW'(1)) >= eff_w;
    assign last_row = ((HEIGHT_W+1)'(r_row) + (HEIGHT_W+1)'(1)) >= (HEIGHT_W+1)'(eff_h);
    assign interior = (r_row >= HEIGHT_W'(2)) && (r_col >= CW'(2));

    always_comb begin
        case (t_cfg_idx'(i_cfg_idx))
            CFG_WIDTH:  cfg_hit = i_cfg_we;
            CFG_HEIGHT: cfg_hit = i_cfg_we;
            default:    cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        sum = $signed({1'b0, r_c1_mid, 2'b00})
            - $signed({3'b000, r_c1_top})
            - $signed({3'b000, r_c1_bot})
            - $signed({3'b000, r_c2_mid})
            - $signed({3'b000, r_rd_mid});
        if (sum[10]) begin
            clamped = '0;
        end else if (sum[9:8] != 2'b00) begin
            clamped = '1;
        end else begin
            clamped = sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            line_two_above[r_col] <= r_rd_mid;
            line_above[r_col]     <= i_pix.pixel;
        end
        r_rd_top <= line_two_above[n_col];
        r_rd_mid <= line_above[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_c1_top <= '0;
            r_c1_mid <= '0;
            r_c1_bot <= '0;
            r_c2_mid <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (cfg_hit) begin
                r_c1_top <= '0;
                r_c1_mid <= '0;
                r_c1_bot <= '0;
                r_c2_mid <= '0;
            end else if (accept) begin
                r_c1_top <= r_rd_top;
                r_c1_mid <= r_rd_mid;
                r_c1_bot <= i_pix.pixel;
                r_c2_mid <= r_c1_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= interior;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && interior) begin
            r_filtered  <= clamped;
            r_row_end   <= last_col;
            r_frame_end <= last_col && last_row;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.filtered  = r_filtered;
    assign o_res.row_end   = r_row_end;
    assign o_res.frame_end = r_frame_end;

endmodule

FILE: rtl/lap3_checker.sv
// ----------------------------------------------------------------------------
// lap3_assertions
// Port-level checks of the Laplacian filter, bound to laplacian_3x3_filter.
// ----------------------------------------------------------------------------
module lap3_assertions (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_row_end,
    input logic i_frame_end
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
    else $error("result dropped while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_row_end)
    else $error("frame end without row end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
    else $error("input stalled with empty output");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (!$past(i_out_valid) || $past(i_out_ready)) && i_out_valid
        |-> $past(i_in_valid && i_in_ready))
    else $error("result without input transfer");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
    else $error("result valid after reset");

endmodule

bind laplacian_3x3_filter lap3_assertions u_lap3_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_row_end   (o_res.row_end),
    .i_frame_end (o_res.frame_end)
);
